// ===== rtl/mipr_pkg.sv =====
package mipr_pkg;

  localparam logic [7:0] MSG_REQ      = 8'd1;
  localparam logic [7:0] MSG_REPLY    = 8'd3;
  localparam logic [7:0] EXT_AUTH_MH  = 8'd32;
  localparam logic [7:0] EXT_AUTH_MF  = 8'd33;
  localparam logic [7:0] EXT_AUTH_FH  = 8'd34;
  localparam logic [7:0] EXT_AUTH_GEN = 8'd36;
  localparam logic [7:0] EXT_NAI      = 8'd131;

  // Generalized authentication header is type, subtype and two length bytes.
  localparam int unsigned GenHdrLen = 4;
  // Smallest authentication extension that holds a full SPI.
  localparam logic [15:0] AuthMinLen = 16'd4;

  typedef enum logic [2:0] {
    PH_FIRST    = 3'd0,
    PH_HEADER   = 3'd1,
    PH_EXT_TYPE = 3'd2,
    PH_EXT_HDR  = 3'd3,
    PH_PAYLOAD  = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    K_TYPE    = 4'd0,
    K_FLAGS   = 4'd1,
    K_CODE    = 4'd2,
    K_LIFE    = 4'd3,
    K_HOME    = 4'd4,
    K_AGENT   = 4'd5,
    K_COA     = 4'd6,
    K_IDENT   = 4'd7,
    K_EXTTYPE = 4'd8,
    K_SUBTYPE = 4'd9,
    K_EXTLEN  = 4'd10,
    K_SPI     = 4'd11,
    K_AUTH    = 4'd12,
    K_NAI     = 4'd13,
    K_DATA    = 4'd14,
    K_END     = 4'd15
  } kind_e;

  function automatic logic is_auth(input logic [7:0] code);
    is_auth = (code == EXT_AUTH_MH) || (code == EXT_AUTH_MF) ||
              (code == EXT_AUTH_FH) || (code == EXT_AUTH_GEN);
  endfunction

endpackage

// ===== rtl/mipr_if.sv =====
interface mipr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mipr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [63:0] field_value;
  logic        message_end;
  logic        truncated;
  logic        malformed;

  modport source (output valid, output field_kind, output field_value, output message_end,
                  output truncated, output malformed, input ready);
  modport sink (input valid, input field_kind, input field_value, input message_end,
                input truncated, input malformed, output ready);
endinterface

// ===== rtl/mobile_ip_registration_parser.sv =====
// Mobile IP registration message parser.
// The msg_i channel carries one message byte per word, in network order, with
// last_byte set on the final byte. The field_o channel carries one word for
// each completed header field, extension header field or tagged payload byte,
// and one end-only word when the last byte completes nothing else.
// A byte is taken in a cycle where msg_i is ready, and its result word appears
// on field_o in the next cycle. One byte is accepted every cycle unless field_o
// stalls; the parser state and the result register are both updated in that
// single cycle.
// The result register holds a word until field_o takes it. While it is full
// and field_o is stalled, msg_i is not ready; a word taken in the same cycle
// frees the register for the next byte.
// Reset empties the result register and puts the parser at the first byte of
// a message. After the last byte of a message the parser returns to the same
// state by itself.
module mobile_ip_registration_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  mipr_in_if.sink     msg_i,
  mipr_out_if.source  field_o
);

  mipr_pkg::phase_e phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [7:0]  msg_type_q, msg_type_d;
  logic [63:0] acc_q, acc_d;
  logic [7:0]  ext_code_q, ext_code_d;
  logic [15:0] ext_len_q, ext_len_d;
  logic [15:0] rem_q, rem_d;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  kind_q;
  logic [63:0] value_q;
  logic        end_q, trunc_q, malf_q;

  logic        in_accept;
  logic        last;
  logic [7:0]  b;
  logic        have;
  logic        malformed;
  mipr_pkg::kind_e kind;
  logic [63:0] value;
  logic [63:0] acc_shift;
  logic [15:0] len;
  logic [15:0] rem_dec;
  logic        is_req;
  logic        hdr_hit;
  logic        hdr_done;
  mipr_pkg::kind_e hdr_kind;
  logic        emit;
  logic        truncated;

  assign b         = msg_i.data_byte;
  assign last      = msg_i.last_byte;
  assign msg_i.ready = !out_valid_q || field_o.ready;
  assign in_accept = msg_i.valid && msg_i.ready;
  assign acc_shift = {acc_q[55:0], b};
  assign is_req    = (msg_type_q == mipr_pkg::MSG_REQ);
  assign rem_dec   = (rem_q != 16'd0) ? rem_q - 16'd1 : rem_q;

  always_comb begin
    hdr_hit  = 1'b1;
    hdr_done = 1'b0;
    hdr_kind = mipr_pkg::K_END;
    case (pos_q)
      5'd1:    hdr_kind = is_req ? mipr_pkg::K_FLAGS : mipr_pkg::K_CODE;
      5'd3:    hdr_kind = mipr_pkg::K_LIFE;
      5'd7:    hdr_kind = mipr_pkg::K_HOME;
      5'd11:   hdr_kind = mipr_pkg::K_AGENT;
      5'd15: begin
        hdr_kind = mipr_pkg::K_COA;
        hdr_hit  = is_req;
      end
      5'd19: begin
        hdr_kind = mipr_pkg::K_IDENT;
        hdr_hit  = !is_req;
        hdr_done = !is_req;
      end
      5'd23: begin
        hdr_kind = mipr_pkg::K_IDENT;
        hdr_hit  = is_req;
        hdr_done = is_req;
      end
      default: hdr_hit = 1'b0;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    msg_type_d = msg_type_q;
    acc_d      = acc_q;
    ext_code_d = ext_code_q;
    ext_len_d  = ext_len_q;
    rem_d      = rem_q;
    have       = 1'b0;
    malformed  = 1'b0;
    kind       = mipr_pkg::K_END;
    value      = 64'd0;
    len        = 16'd0;

    case (phase_q)
      mipr_pkg::PH_FIRST: begin
        msg_type_d = b;
        acc_d      = 64'd0;
        have       = 1'b1;
        value      = {56'd0, b};
        if (b == mipr_pkg::MSG_REQ || b == mipr_pkg::MSG_REPLY) begin
          kind    = mipr_pkg::K_TYPE;
          phase_d = mipr_pkg::PH_HEADER;
          pos_d   = 5'd1;
        end else begin
          // Unknown message types are walked as extensions from the first byte.
          ext_code_d = b;
          kind       = mipr_pkg::K_EXTTYPE;
          phase_d    = mipr_pkg::PH_EXT_HDR;
          pos_d      = 5'd0;
        end
      end
      mipr_pkg::PH_HEADER: begin
        acc_d = acc_shift;
        pos_d = pos_q + 5'd1;
        if (hdr_hit) begin
          have  = 1'b1;
          kind  = hdr_kind;
          value = acc_shift;
          acc_d = 64'd0;
        end
        if (hdr_done) begin
          phase_d = mipr_pkg::PH_EXT_TYPE;
          pos_d   = 5'd0;
        end
      end
      mipr_pkg::PH_EXT_TYPE: begin
        ext_code_d = b;
        have       = 1'b1;
        kind       = mipr_pkg::K_EXTTYPE;
        value      = {56'd0, b};
        phase_d    = mipr_pkg::PH_EXT_HDR;
        pos_d      = 5'd0;
        acc_d      = 64'd0;
      end
      mipr_pkg::PH_EXT_HDR: begin
        if (ext_code_q == mipr_pkg::EXT_AUTH_GEN && pos_q == 5'd0) begin
          have  = 1'b1;
          kind  = mipr_pkg::K_SUBTYPE;
          value = {56'd0, b};
          pos_d = 5'd1;
          acc_d = 64'd0;
        end else if (ext_code_q == mipr_pkg::EXT_AUTH_GEN &&
                     pos_q < 5'(mipr_pkg::GenHdrLen - 2)) begin
          acc_d = acc_shift;
          pos_d = pos_q + 5'd1;
        end else begin
          len       = (ext_code_q == mipr_pkg::EXT_AUTH_GEN) ? acc_shift[15:0] : {8'd0, b};
          have      = 1'b1;
          kind      = mipr_pkg::K_EXTLEN;
          value     = {48'd0, len};
          ext_len_d = len;
          rem_d     = len;
          malformed = mipr_pkg::is_auth(ext_code_q) && (len < mipr_pkg::AuthMinLen);
          pos_d     = 5'd0;
          acc_d     = 64'd0;
          phase_d   = (len == 16'd0) ? mipr_pkg::PH_EXT_TYPE : mipr_pkg::PH_PAYLOAD;
        end
      end
      default: begin
        have  = 1'b1;
        value = {56'd0, b};
        if (mipr_pkg::is_auth(ext_code_q) && ext_len_q >= mipr_pkg::AuthMinLen) begin
          if (pos_q < 5'd4) begin
            kind  = mipr_pkg::K_END;
            have  = 1'b0;
            value = 64'd0;
            acc_d = {32'd0, acc_q[23:0], b};
            pos_d = pos_q + 5'd1;
            if (pos_q == 5'd3) begin
              have  = 1'b1;
              kind  = mipr_pkg::K_SPI;
              value = {32'd0, acc_q[23:0], b};
              acc_d = 64'd0;
            end
          end else begin
            kind = mipr_pkg::K_AUTH;
          end
        end else if (ext_code_q == mipr_pkg::EXT_NAI) begin
          kind = mipr_pkg::K_NAI;
        end else begin
          kind = mipr_pkg::K_DATA;
        end
        rem_d = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_d = mipr_pkg::PH_EXT_TYPE;
          pos_d   = 5'd0;
        end
      end
    endcase
  end

  assign emit      = have || last;
  assign truncated = last && (phase_d != mipr_pkg::PH_EXT_TYPE);

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = emit;
    end else if (field_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mipr_pkg::PH_FIRST;
      pos_q       <= 5'd0;
      msg_type_q  <= 8'd0;
      acc_q       <= 64'd0;
      ext_code_q  <= 8'd0;
      ext_len_q   <= 16'd0;
      rem_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        if (last) begin
          phase_q    <= mipr_pkg::PH_FIRST;
          pos_q      <= 5'd0;
          msg_type_q <= 8'd0;
          acc_q      <= 64'd0;
          ext_code_q <= 8'd0;
          ext_len_q  <= 16'd0;
          rem_q      <= 16'd0;
        end else begin
          phase_q    <= phase_d;
          pos_q      <= pos_d;
          msg_type_q <= msg_type_d;
          acc_q      <= acc_d;
          ext_code_q <= ext_code_d;
          ext_len_q  <= ext_len_d;
          rem_q      <= rem_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      kind_q  <= kind;
      value_q <= value;
      end_q   <= last;
      trunc_q <= truncated;
      malf_q  <= malformed;
    end
  end

  assign field_o.valid       = out_valid_q;
  assign field_o.field_kind  = kind_q;
  assign field_o.field_value = value_q;
  assign field_o.message_end = end_q;
  assign field_o.truncated   = trunc_q;
  assign field_o.malformed   = malf_q;

  a_trunc_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_o.valid && field_o.truncated |-> field_o.message_end)
    else $error("truncated word without message end");

  a_malf_on_extlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_o.valid && field_o.malformed |-> field_o.field_kind == mipr_pkg::K_EXTLEN)
    else $error("malformed flag on a word that is not an extension length");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && last |=> phase_q == mipr_pkg::PH_FIRST && pos_q == 5'd0)
    else $error("parser did not return to the first byte after the last byte");

  a_payload_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mipr_pkg::PH_PAYLOAD |-> rem_q != 16'd0)
    else $error("payload phase with no bytes remaining");

endmodule
